// File: sv/adw_pkg.sv
// Shared types, constants and helpers of the Adadelta weight update block.
package adw_pkg;

  localparam int unsigned NUM_WEIGHTS_DEF = 4096;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned AVG_W      = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DVD_W      = 96;
  localparam int unsigned DEN_W      = 49;
  localparam int unsigned CNT_W      = 7;

  localparam logic [AVG_W-1:0] MAX48 = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_STRENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_STRENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT = 3'd4;

  localparam logic [15:0] DECAY_RATE_RST  = 16'd62259;
  localparam logic [31:0] EPSILON_RST     = 32'd4295;
  localparam logic [15:0] L1_STRENGTH_RST = 16'd0;
  localparam logic [15:0] L2_STRENGTH_RST = 16'd0;
  localparam logic [15:0] BATCH_COUNT_RST = 16'd1;

  typedef struct packed {
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] weight_value;
    logic signed [VAL_W-1:0] grad_value;
    logic [15:0]             l1_scale;
    logic [15:0]             l2_scale;
    logic                    clear_losses;
  } adw_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] updated_weight;
    logic [AVG_W-1:0]        l1_loss_sum;
    logic [AVG_W-1:0]        l2_loss_sum;
  } adw_out_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] weight_value;
    logic signed [VAL_W-1:0] grad_value;
    logic [15:0]             l1_scale;
    logic [15:0]             l2_scale;
    logic                    clear_losses;
  } adw_item_t;

  typedef struct packed {
    logic [15:0] decay_rate;
    logic [31:0] epsilon;
    logic [15:0] l1_strength;
    logic [15:0] l2_strength;
    logic [15:0] batch_count;
  } adw_cfg_t;

  typedef enum logic [3:0] {
    BK_CLEAR, BK_IDLE, BK_MLO, BK_MHI, BK_MACC, BK_POST, BK_BDIV, BK_BWAIT,
    BK_RDIV, BK_RWAIT, BK_SQRT, BK_SWAIT, BK_EMIT
  } back_state_e;

  typedef enum logic [3:0] {
    OP_D1, OP_D2, OP_L1, OP_WSQ, OP_L2, OP_D2W, OP_RG, OP_GSQ, OP_GT,
    OP_DX, OP_RX, OP_DSQ, OP_ST
  } op_e;

  function automatic logic [AVG_W-1:0] add_sat48(input logic [AVG_W-1:0] a,
                                                 input logic [AVG_W-1:0] b);
    logic [AVG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AVG_W] ? MAX48 : s[AVG_W-1:0];
  endfunction

endpackage

// File: sv/adw_stream_if.sv
// Valid/ready stream channel carrying one word of type T.
interface adw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/adw_front.sv
// Front end: accept words, fold the element index into range, queue for the back end.
module adw_front #(
  parameter int unsigned NUM_WEIGHTS = adw_pkg::NUM_WEIGHTS_DEF,
  parameter int unsigned IW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  adw_stream_if.sink          in_if,
  input  logic                clearing_i,
  input  logic                q_pop_i,
  output logic                q_valid_o,
  output adw_pkg::adw_item_t  q_item_o,
  output logic [IW-1:0]       q_idx_o
);

  localparam int unsigned RW = (IW > 12) ? IW + 1 : 13;
  localparam logic [RW-1:0] NW = RW'(NUM_WEIGHTS);

  logic                      stg_v_q, red_q;
  adw_pkg::adw_item_t        stg_item_q;
  logic [adw_pkg::IDX_W-1:0] stg_src_q;
  logic [3:0]                cnt_q;
  logic [RW-1:0]             rem_q, rem_sh, rem_d, idx_ext;
  logic                      accept, push;

  adw_pkg::adw_item_t item_mem_q [2];
  logic [IW-1:0]      idx_mem_q [2];
  logic               wr_q, rd_q;
  logic [1:0]         fill_q;

  assign in_if.ready = !stg_v_q && !clearing_i;
  assign accept      = in_if.valid && in_if.ready;
  assign idx_ext     = {{(RW - adw_pkg::IDX_W){1'b0}}, in_if.data.element_index};
  assign rem_sh      = {rem_q[RW-2:0], stg_src_q[cnt_q]};
  assign rem_d       = (rem_sh >= NW) ? rem_sh - NW : rem_sh;
  assign push        = stg_v_q && !red_q && (fill_q != 2'd2);

  assign q_valid_o = (fill_q != 2'd0);
  assign q_item_o  = item_mem_q[rd_q];
  assign q_idx_o   = idx_mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      red_q   <= 1'b0;
      cnt_q   <= '0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      fill_q  <= '0;
    end else begin
      if (accept) begin
        stg_v_q <= 1'b1;
        red_q   <= (idx_ext >= NW);
        cnt_q   <= 4'd11;
      end else if (push) begin
        stg_v_q <= 1'b0;
      end else if (red_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          red_q <= 1'b0;
        end
      end
      if (push) begin
        wr_q <= !wr_q;
      end
      if (q_pop_i) begin
        rd_q <= !rd_q;
      end
      unique case ({push, q_pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_item_q.weight_value <= in_if.data.weight_value;
      stg_item_q.grad_value   <= in_if.data.grad_value;
      stg_item_q.l1_scale     <= in_if.data.l1_scale;
      stg_item_q.l2_scale     <= in_if.data.l2_scale;
      stg_item_q.clear_losses <= in_if.data.clear_losses;
      stg_src_q               <= in_if.data.element_index;
      rem_q                   <= (idx_ext >= NW) ? '0 : idx_ext;
    end else if (red_q) begin
      rem_q <= rem_d;
    end
    if (push) begin
      item_mem_q[wr_q] <= stg_item_q;
      idx_mem_q[wr_q]  <= rem_q[IW-1:0];
    end
  end

endmodule

// File: sv/adw_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module adw_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [adw_pkg::DVD_W-1:0]   dividend_i,
  input  logic [adw_pkg::DEN_W-1:0]   divisor_i,
  input  logic [adw_pkg::CNT_W-1:0]   steps_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [adw_pkg::DVD_W-1:0]   quot_o
);

  logic                      busy_q, done_q, ge;
  logic [adw_pkg::CNT_W-1:0] cnt_q;
  logic [adw_pkg::DVD_W-1:0] dvd_q, quot_q;
  logic [adw_pkg::DEN_W-1:0] den_q, rem_q;
  logic [adw_pkg::DEN_W:0]   remn, diff;

  assign remn   = {rem_q, dvd_q[adw_pkg::DVD_W-1]};
  assign ge     = (remn >= {1'b0, den_q});
  assign diff   = remn - {1'b0, den_q};
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[adw_pkg::DVD_W-2:0], 1'b0};
      rem_q  <= ge ? diff[adw_pkg::DEN_W-1:0] : remn[adw_pkg::DEN_W-1:0];
      quot_q <= {quot_q[adw_pkg::DVD_W-2:0], ge};
    end
  end

endmodule

// File: sv/adw_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module adw_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q, ge;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] remn, trial, diff;

  assign remn   = {rem_q, rad_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (remn >= trial);
  assign diff   = remn - trial;
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= ge ? diff[33:0] : remn[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

endmodule

// File: sv/adw_back.sv
// Back end: per-weight arithmetic sequencer, average memories and result register.
module adw_back #(
  parameter int unsigned NUM_WEIGHTS = adw_pkg::NUM_WEIGHTS_DEF,
  parameter int unsigned IW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adw_pkg::adw_cfg_t   cfg_i,
  input  logic                q_valid_i,
  input  adw_pkg::adw_item_t  q_item_i,
  input  logic [IW-1:0]       q_idx_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  adw_stream_if.source        out_if
);

  localparam logic [IW-1:0] LAST = IW'(NUM_WEIGHTS - 1);

  adw_pkg::back_state_e state_q, state_d;
  adw_pkg::op_e         op_q, op_d;
  logic [IW-1:0]        clr_addr_q, idx_q, waddr;

  logic signed [31:0] w_q, g_q;
  logic [15:0]        l1sc_q, l2sc_q;
  logic               clr_q, wpos;
  logic [31:0]        wmag_q, d1_q, d2_q, gmag_q, gmag_d;
  logic               gneg_q, gneg_d;
  logic [63:0]        wsq_q, gsq_q, dsq_q, acc_q, acc_d, acc_mag;
  logic [47:0]        l1acc_q, l2acc_q, rg_q, gnew_q, dx_q, rx_q, gold_q, x_q;
  logic [47:0]        term_l1, term_l2, term_g, term_s, gnew_d, snew_d, gm48, cap48;
  logic [63:0]        opa, mul_p_q, mul_p_d, p0_q, dw, d1s, gsh;
  logic [31:0]        opb, mul_x;
  logic [95:0]        prod_q;
  logic [16:0]        om;
  logic [15:0]        bc;
  logic [48:0]        den_sum, den, num;
  logic signed [49:0] nw_wide;
  logic [31:0]        nw_q, nw_d;

  logic                        div_start, div_busy, div_done;
  logic [adw_pkg::DVD_W-1:0]   div_dvd, div_quot;
  logic [adw_pkg::DEN_W-1:0]   div_den;
  logic [adw_pkg::CNT_W-1:0]   div_steps;
  logic                        sqrt_start, sqrt_busy, sqrt_done;
  logic [63:0]                 sqrt_rad;
  logic [31:0]                 sqrt_root;
  logic                        g_we, s_we, emit_load, q_pop;
  logic [47:0]                 g_wdata, s_wdata;

  logic                 out_valid_q;
  adw_pkg::adw_out_t    out_data_q;

  logic [47:0] grad_mem [NUM_WEIGHTS];
  logic [47:0] step_mem [NUM_WEIGHTS];

  assign clearing_o   = (state_q == adw_pkg::BK_CLEAR);
  assign q_pop_o      = q_pop;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  assign om   = 17'd65536 - {1'b0, cfg_i.decay_rate};
  assign bc   = (cfg_i.batch_count == 16'd0) ? 16'd1 : cfg_i.batch_count;
  assign wpos = !w_q[31] && (w_q != 32'sd0);

  // operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (op_q)
      adw_pkg::OP_D1:  begin opa = {48'b0, cfg_i.l1_strength}; opb = {16'b0, l1sc_q}; end
      adw_pkg::OP_D2:  begin opa = {48'b0, cfg_i.l2_strength}; opb = {16'b0, l2sc_q}; end
      adw_pkg::OP_L1:  begin opa = {32'b0, wmag_q}; opb = d1_q; end
      adw_pkg::OP_WSQ: begin opa = {32'b0, wmag_q}; opb = wmag_q; end
      adw_pkg::OP_L2:  begin opa = wsq_q; opb = d2_q; end
      adw_pkg::OP_D2W: begin opa = {32'b0, wmag_q}; opb = d2_q; end
      adw_pkg::OP_RG:  begin opa = {16'b0, gold_q}; opb = {16'b0, cfg_i.decay_rate}; end
      adw_pkg::OP_GSQ: begin opa = {32'b0, gmag_q}; opb = gmag_q; end
      adw_pkg::OP_GT:  begin opa = gsq_q; opb = {15'b0, om}; end
      adw_pkg::OP_DX:  begin opa = {32'b0, sqrt_root}; opb = gmag_q; end
      adw_pkg::OP_RX:  begin opa = {16'b0, x_q}; opb = {16'b0, cfg_i.decay_rate}; end
      adw_pkg::OP_DSQ: begin opa = {32'b0, dx_q[31:0]}; opb = dx_q[31:0]; end
      adw_pkg::OP_ST:  begin opa = dsq_q; opb = {15'b0, om}; end
      default:         begin opa = '0; opb = '0; end
    endcase
  end

  assign mul_x   = (state_q == adw_pkg::BK_MHI) ? opa[63:32] : opa[31:0];
  assign mul_p_d = mul_x * opb;

  // post-multiply arithmetic
  always_comb begin
    term_l1 = (|prod_q[95:56]) ? adw_pkg::MAX48 : prod_q[55:8];
    term_l2 = (|prod_q[95:73]) ? adw_pkg::MAX48 : prod_q[72:25];
    term_g  = (|prod_q[95:64]) ? adw_pkg::MAX48 : prod_q[63:16];
    term_s  = (|dx_q[47:32]) ? adw_pkg::MAX48 : term_g;
    gnew_d  = adw_pkg::add_sat48(rg_q, term_g);
    snew_d  = adw_pkg::add_sat48(rx_q, term_s);
    gsh     = {{16{g_q[31]}}, g_q, 16'b0};
    dw      = {8'b0, prod_q[63:8]};
    d1s     = {24'b0, d1_q, 8'b0};
    acc_d   = gsh + (w_q[31] ? (64'd0 - dw) : dw) + (wpos ? d1s : (64'd0 - d1s));
    acc_mag = acc_q[63] ? (64'd0 - acc_q) : acc_q;
    gneg_d  = acc_q[63] && (div_quot[63:0] != 64'd0);
    gm48    = div_quot[63:16];
    cap48   = gneg_d ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    gmag_d  = (gm48 > cap48) ? cap48[31:0] : gm48[31:0];
    den_sum = {1'b0, gnew_q} + {17'b0, cfg_i.epsilon};
    den     = (den_sum == 49'd0) ? 49'd1 : den_sum;
    num     = {1'b0, x_q} + {17'b0, cfg_i.epsilon};
    nw_wide = gneg_q ? ($signed({{18{w_q[31]}}, w_q}) + $signed({2'b00, dx_q}))
                     : ($signed({{18{w_q[31]}}, w_q}) - $signed({2'b00, dx_q}));
    if (nw_wide > 50'sd2147483647) begin
      nw_d = 32'h7FFF_FFFF;
    end else if (nw_wide < -50'sd2147483648) begin
      nw_d = 32'h8000_0000;
    end else begin
      nw_d = nw_wide[31:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      adw_pkg::BK_CLEAR: if (clr_addr_q == LAST) state_d = adw_pkg::BK_IDLE;
      adw_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          state_d = adw_pkg::BK_MLO;
          op_d    = adw_pkg::OP_D1;
        end
      end
      adw_pkg::BK_MLO:  state_d = adw_pkg::BK_MHI;
      adw_pkg::BK_MHI:  state_d = adw_pkg::BK_MACC;
      adw_pkg::BK_MACC: state_d = adw_pkg::BK_POST;
      adw_pkg::BK_POST: begin
        state_d = adw_pkg::BK_MLO;
        unique case (op_q)
          adw_pkg::OP_D1:  op_d = adw_pkg::OP_D2;
          adw_pkg::OP_D2:  op_d = adw_pkg::OP_L1;
          adw_pkg::OP_L1:  op_d = adw_pkg::OP_WSQ;
          adw_pkg::OP_WSQ: op_d = adw_pkg::OP_L2;
          adw_pkg::OP_L2:  op_d = adw_pkg::OP_D2W;
          adw_pkg::OP_D2W: state_d = adw_pkg::BK_BDIV;
          adw_pkg::OP_RG:  op_d = adw_pkg::OP_GSQ;
          adw_pkg::OP_GSQ: op_d = adw_pkg::OP_GT;
          adw_pkg::OP_GT:  state_d = adw_pkg::BK_RDIV;
          adw_pkg::OP_DX:  op_d = adw_pkg::OP_RX;
          adw_pkg::OP_RX:  op_d = adw_pkg::OP_DSQ;
          adw_pkg::OP_DSQ: op_d = adw_pkg::OP_ST;
          adw_pkg::OP_ST:  state_d = adw_pkg::BK_EMIT;
          default:         state_d = adw_pkg::BK_IDLE;
        endcase
      end
      adw_pkg::BK_BDIV: state_d = adw_pkg::BK_BWAIT;
      adw_pkg::BK_BWAIT: begin
        if (div_done) begin
          state_d = adw_pkg::BK_MLO;
          op_d    = adw_pkg::OP_RG;
        end
      end
      adw_pkg::BK_RDIV: state_d = adw_pkg::BK_RWAIT;
      adw_pkg::BK_RWAIT: if (div_done) state_d = adw_pkg::BK_SQRT;
      adw_pkg::BK_SQRT: state_d = adw_pkg::BK_SWAIT;
      adw_pkg::BK_SWAIT: begin
        if (sqrt_done) begin
          state_d = adw_pkg::BK_MLO;
          op_d    = adw_pkg::OP_DX;
        end
      end
      adw_pkg::BK_EMIT: if (!out_valid_q || out_if.ready) state_d = adw_pkg::BK_IDLE;
      default: state_d = adw_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop      = (state_q == adw_pkg::BK_IDLE) && q_valid_i;
    div_start  = (state_q == adw_pkg::BK_BDIV) || (state_q == adw_pkg::BK_RDIV);
    div_dvd    = (state_q == adw_pkg::BK_BDIV) ? {acc_mag, 32'b0} : {num, 47'b0};
    div_den    = (state_q == adw_pkg::BK_BDIV) ? {33'b0, bc} : den;
    div_steps  = (state_q == adw_pkg::BK_BDIV) ? 7'd64 : 7'd81;
    sqrt_start = (state_q == adw_pkg::BK_SQRT);
    sqrt_rad   = (|div_quot[95:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : div_quot[63:0];
    emit_load  = (state_q == adw_pkg::BK_EMIT) && (!out_valid_q || out_if.ready);
    g_we       = (state_q == adw_pkg::BK_CLEAR) ||
                 ((state_q == adw_pkg::BK_POST) && (op_q == adw_pkg::OP_GT));
    s_we       = (state_q == adw_pkg::BK_CLEAR) ||
                 ((state_q == adw_pkg::BK_POST) && (op_q == adw_pkg::OP_ST));
    waddr      = (state_q == adw_pkg::BK_CLEAR) ? clr_addr_q : idx_q;
    g_wdata    = (state_q == adw_pkg::BK_CLEAR) ? 48'd0 : gnew_d;
    s_wdata    = (state_q == adw_pkg::BK_CLEAR) ? 48'd0 : snew_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= adw_pkg::BK_CLEAR;
      op_q        <= adw_pkg::OP_D1;
      clr_addr_q  <= '0;
      l1acc_q     <= '0;
      l2acc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (state_q == adw_pkg::BK_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if ((state_q == adw_pkg::BK_POST) && (op_q == adw_pkg::OP_L1)) begin
        l1acc_q <= adw_pkg::add_sat48(clr_q ? 48'd0 : l1acc_q, term_l1);
      end
      if ((state_q == adw_pkg::BK_POST) && (op_q == adw_pkg::OP_L2)) begin
        l2acc_q <= adw_pkg::add_sat48(clr_q ? 48'd0 : l2acc_q, term_l2);
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_p_d;
    if (state_q == adw_pkg::BK_MHI) begin
      p0_q <= mul_p_q;
    end
    if (state_q == adw_pkg::BK_MACC) begin
      prod_q <= {32'b0, p0_q} + {mul_p_q, 32'b0};
    end
    if (q_pop) begin
      w_q    <= q_item_i.weight_value;
      g_q    <= q_item_i.grad_value;
      l1sc_q <= q_item_i.l1_scale;
      l2sc_q <= q_item_i.l2_scale;
      clr_q  <= q_item_i.clear_losses;
      idx_q  <= q_idx_i;
      wmag_q <= q_item_i.weight_value[31] ? (32'd0 - q_item_i.weight_value)
                                          : q_item_i.weight_value;
    end
    if (state_q == adw_pkg::BK_POST) begin
      unique case (op_q)
        adw_pkg::OP_D1:  d1_q   <= prod_q[31:0];
        adw_pkg::OP_D2:  d2_q   <= prod_q[31:0];
        adw_pkg::OP_WSQ: wsq_q  <= prod_q[63:0];
        adw_pkg::OP_D2W: acc_q  <= acc_d;
        adw_pkg::OP_RG:  rg_q   <= prod_q[63:16];
        adw_pkg::OP_GSQ: gsq_q  <= prod_q[63:0];
        adw_pkg::OP_GT:  gnew_q <= gnew_d;
        adw_pkg::OP_DX:  dx_q   <= prod_q[63:16];
        adw_pkg::OP_RX:  rx_q   <= prod_q[63:16];
        adw_pkg::OP_DSQ: dsq_q  <= prod_q[63:0];
        adw_pkg::OP_ST:  nw_q   <= nw_d;
        default:         d1_q   <= d1_q;
      endcase
    end
    if ((state_q == adw_pkg::BK_BWAIT) && div_done) begin
      gneg_q <= gneg_d;
      gmag_q <= gmag_d;
    end
    if (emit_load) begin
      out_data_q.updated_weight <= nw_q;
      out_data_q.l1_loss_sum    <= l1acc_q;
      out_data_q.l2_loss_sum    <= l2acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      grad_mem[waddr] <= g_wdata;
    end
    if (q_pop) begin
      gold_q <= grad_mem[q_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      step_mem[waddr] <= s_wdata;
    end
    if (q_pop) begin
      x_q <= step_mem[q_idx_i];
    end
  end

  adw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  adw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (state_q == adw_pkg::BK_MLO) && (op_q == adw_pkg::OP_D1))
    else $error("pop did not start the sequence");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_busy)
    else $error("square root started while busy");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (g_we || s_we) |-> !q_pop)
    else $error("memory write overlaps a pop");

endmodule

// File: sv/adadelta_weight_update_top.sv
// Adadelta weight update top level: configuration registers, front end and back end.
// One weight word in gives one result word out, in order. In the back end each word
// takes 13 multiply steps on one shared 32x32 multiplier, a 64-step bit-serial
// divide by the batch size, an 81-step divide for the average ratio and a 32-step
// square root; the next word is accepted by the front end meanwhile and waits in a
// two-entry queue. After reset a clearing pass zeroes both average memories, one
// entry per cycle, and no input word is taken until it ends. An index at or above
// NUM_WEIGHTS wraps modulo NUM_WEIGHTS, which the front end works out bit by bit.
module adadelta_weight_update_top #(
  parameter int unsigned NUM_WEIGHTS = adw_pkg::NUM_WEIGHTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  adw_stream_if.sink                      in_if,
  adw_stream_if.source                    out_if,
  input  logic                            cfg_we_i,
  input  logic [adw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [adw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

  adw_pkg::adw_cfg_t  cfg_q;
  logic               q_valid, q_pop, clearing;
  adw_pkg::adw_item_t q_item;
  logic [IW-1:0]      q_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_rate  <= adw_pkg::DECAY_RATE_RST;
      cfg_q.epsilon     <= adw_pkg::EPSILON_RST;
      cfg_q.l1_strength <= adw_pkg::L1_STRENGTH_RST;
      cfg_q.l2_strength <= adw_pkg::L2_STRENGTH_RST;
      cfg_q.batch_count <= adw_pkg::BATCH_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adw_pkg::CFG_DECAY_RATE:  cfg_q.decay_rate  <= cfg_data_i[15:0];
        adw_pkg::CFG_EPSILON:     cfg_q.epsilon     <= cfg_data_i;
        adw_pkg::CFG_L1_STRENGTH: cfg_q.l1_strength <= cfg_data_i[15:0];
        adw_pkg::CFG_L2_STRENGTH: cfg_q.l2_strength <= cfg_data_i[15:0];
        adw_pkg::CFG_BATCH_COUNT: cfg_q.batch_count <= cfg_data_i[15:0];
        default:                  cfg_q <= cfg_q;
      endcase
    end
  end

  adw_front #(
    .NUM_WEIGHTS (NUM_WEIGHTS),
    .IW          (IW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .clearing_i (clearing),
    .q_pop_i    (q_pop),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_idx_o    (q_idx)
  );

  adw_back #(
    .NUM_WEIGHTS (NUM_WEIGHTS),
    .IW          (IW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_idx_i    (q_idx),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .out_if     (out_if)
  );

endmodule
